[design/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Shared widths, command codes and the result record of the deque.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int CMD_W        = 3;
	localparam int IDX_W        = 10;
	localparam int VAL_W        = 64;
	localparam int CNT_W        = 11;
	localparam int DEF_CAPACITY = 1024;

	localparam int IN_BITS  = CMD_W + IDX_W + VAL_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int RES_BITS = VAL_W + 1 + VAL_W + VAL_W + CNT_W + 1;
	localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_PUSH_L = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_R = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_L  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_R  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_SET    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_REV    = 3'd6;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd7;

	typedef struct packed {
		logic                    reversed;
		logic [CNT_W-1:0]        count;
		logic signed [VAL_W-1:0] right_end;
		logic signed [VAL_W-1:0] left_end;
		logic                    ok;
		logic signed [VAL_W-1:0] read_value;
	} res_t;

endpackage

[design/deq_ram.sv]
// ----------------------------------------------------------------------------
// deq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
	parameter int DEPTH = deq_pkg::DEF_CAPACITY,
	parameter int AW    = 10,
	parameter int W     = deq_pkg::VAL_W
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/deq_core.sv]
// ----------------------------------------------------------------------------
// deq_core
// Ring pointers, end values and the command sequencer around the entry store.
// ----------------------------------------------------------------------------
module deq_core #(
	parameter int CAPACITY = deq_pkg::DEF_CAPACITY
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [deq_pkg::CMD_W-1:0]     in_cmd,
	input  logic [deq_pkg::IDX_W-1:0]     in_index,
	input  logic [deq_pkg::VAL_W-1:0]     in_value,
	output logic                          res_valid,
	input  logic                          res_ready,
	output deq_pkg::res_t                 res
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > deq_pkg::IDX_W) ? CW : deq_pkg::IDX_W;
	localparam logic [AW:0]   CAP_X     = (AW + 1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C     = CW'(CAPACITY);
	localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_RESP = 2'd2;

	logic [1:0]                  state_q;
	logic [deq_pkg::CMD_W-1:0]   cmd_q;
	logic [deq_pkg::IDX_W-1:0]   idx_q;
	logic [deq_pkg::VAL_W-1:0]   val_q;
	logic [AW-1:0]               front_q;
	logic [CW-1:0]               count_q;
	logic                        rev_q;
	logic [deq_pkg::VAL_W-1:0]   lend_q;
	logic [deq_pkg::VAL_W-1:0]   rend_q;
	logic                        ok_q;
	logic                        get_q;
	logic                        fixl_q;
	logic                        fixr_q;

	logic [XW-1:0]               cnt_x;
	logic [XW-1:0]               idx_x;
	logic [XW-1:0]               phys_x;
	logic [XW-1:0]               off_x;
	logic                        empty;
	logic                        full;
	logic                        idx_ok;
	logic                        at_front;
	logic [AW:0]                 sum;
	logic [AW:0]                 sum_wrap;
	logic [AW-1:0]               slot;
	logic [AW-1:0]               front_dec;
	logic                        exec_ok;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic                        mem_re;
	logic [deq_pkg::VAL_W-1:0]   rdata;
	logic [deq_pkg::VAL_W-1:0]   lend_n;
	logic [deq_pkg::VAL_W-1:0]   rend_n;

	deq_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW),
		.W     (deq_pkg::VAL_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (val_q),
		.re    (mem_re),
		.raddr (slot),
		.rdata (rdata)
	);

	assign in_ready = (state_q == ST_IDLE);

	assign cnt_x  = XW'(count_q);
	assign idx_x  = XW'(idx_q);
	assign empty  = (count_q == '0);
	assign full   = (count_q == CAP_C);
	assign idx_ok = (idx_x < cnt_x);
	assign phys_x = rev_q ? (cnt_x - XW'(1) - idx_x) : idx_x;

	always_comb begin
		case (cmd_q)
			deq_pkg::CMD_PUSH_L, deq_pkg::CMD_POP_L: at_front = !rev_q;
			default:                                 at_front = rev_q;
		endcase
	end

	always_comb begin
		case (cmd_q)
			deq_pkg::CMD_PUSH_L, deq_pkg::CMD_PUSH_R: off_x = cnt_x;
			deq_pkg::CMD_POP_L, deq_pkg::CMD_POP_R:
				off_x = at_front ? XW'(1) : (cnt_x - XW'(2));
			default: off_x = phys_x;
		endcase
	end

	assign sum       = {1'b0, front_q} + {1'b0, off_x[AW-1:0]};
	assign sum_wrap  = sum - CAP_X;
	assign slot      = (sum >= CAP_X) ? sum_wrap[AW-1:0] : sum[AW-1:0];
	assign front_dec = (front_q == '0) ? LAST_SLOT : (front_q - AW'(1));

	always_comb begin
		exec_ok   = 1'b1;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = slot;
		case (cmd_q)
			deq_pkg::CMD_PUSH_L, deq_pkg::CMD_PUSH_R: begin
				exec_ok   = !full;
				mem_we    = !full;
				mem_waddr = at_front ? front_dec : slot;
			end
			deq_pkg::CMD_POP_L, deq_pkg::CMD_POP_R: begin
				exec_ok = !empty;
				mem_re  = !empty;
			end
			deq_pkg::CMD_GET: begin
				exec_ok = idx_ok;
				mem_re  = idx_ok;
			end
			deq_pkg::CMD_SET: begin
				exec_ok = idx_ok;
				mem_we  = idx_ok;
			end
			default: begin
				exec_ok = 1'b1;
			end
		endcase
		if (state_q != ST_EXEC) begin
			mem_we = 1'b0;
			mem_re = 1'b0;
		end
	end

	assign lend_n = fixl_q ? rdata : lend_q;
	assign rend_n = fixr_q ? rdata : rend_q;

	assign res_valid      = (state_q == ST_RESP);
	assign res.read_value = get_q ? rdata : '0;
	assign res.ok         = ok_q;
	assign res.left_end   = rev_q ? rend_n : lend_n;
	assign res.right_end  = rev_q ? lend_n : rend_n;
	assign res.count      = deq_pkg::CNT_W'(count_q);
	assign res.reversed   = rev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= '0;
			idx_q   <= '0;
			val_q   <= '0;
			front_q <= '0;
			count_q <= '0;
			rev_q   <= 1'b0;
			lend_q  <= '0;
			rend_q  <= '0;
			ok_q    <= 1'b0;
			get_q   <= 1'b0;
			fixl_q  <= 1'b0;
			fixr_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q   <= in_cmd;
						idx_q   <= in_index;
						val_q   <= in_value;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					ok_q    <= exec_ok;
					get_q   <= 1'b0;
					fixl_q  <= 1'b0;
					fixr_q  <= 1'b0;
					state_q <= ST_RESP;
					case (cmd_q)
						deq_pkg::CMD_PUSH_L, deq_pkg::CMD_PUSH_R: begin
							if (!full) begin
								count_q <= count_q + CW'(1);
								if (at_front) begin
									front_q <= front_dec;
									lend_q  <= val_q;
									if (empty) begin
										rend_q <= val_q;
									end
								end else begin
									rend_q <= val_q;
									if (empty) begin
										lend_q <= val_q;
									end
								end
							end
						end
						deq_pkg::CMD_POP_L, deq_pkg::CMD_POP_R: begin
							if (!empty) begin
								count_q <= count_q - CW'(1);
								if (at_front) begin
									front_q <= slot;
								end
								if (count_q == CW'(1)) begin
									lend_q <= '0;
									rend_q <= '0;
								end else begin
									fixl_q <= at_front;
									fixr_q <= !at_front;
								end
							end
						end
						deq_pkg::CMD_GET: begin
							get_q <= idx_ok;
						end
						deq_pkg::CMD_SET: begin
							if (idx_ok) begin
								if (phys_x == '0) begin
									lend_q <= val_q;
								end
								if (phys_x == cnt_x - XW'(1)) begin
									rend_q <= val_q;
								end
							end
						end
						deq_pkg::CMD_REV: begin
							rev_q <= !rev_q;
						end
						default: begin
							rev_q <= rev_q;
						end
					endcase
				end
				ST_RESP: begin
					if (res_ready) begin
						lend_q  <= lend_n;
						rend_q  <= rend_n;
						fixl_q  <= 1'b0;
						fixr_q  <= 1'b0;
						get_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[design/indexable_reversible_deque_top.sv]
// ----------------------------------------------------------------------------
// indexable_reversible_deque_top
// Indexable deque of signed 64-bit values with constant-time reverse.
// ----------------------------------------------------------------------------
// Each request moves through capture, one access to the entry memory (write,
// or read for get and for the new end after a pop), and the response state in
// which the registered read data settles the ends; a new request is taken only
// once the previous result has moved into the output register. The entry
// memory needs no clearing pass after reset. A result sits in the output
// register while the next request is taken.
// ----------------------------------------------------------------------------
module indexable_reversible_deque_top #(
	parameter int CAPACITY = deq_pkg::DEF_CAPACITY
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [deq_pkg::IN_W-1:0]  s_tdata,  // cmd, index, value
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [deq_pkg::OUT_W-1:0] m_tdata   // read_value, ok, left_end, right_end,
	                                            // count, reversed
);

	localparam int P0 = deq_pkg::CMD_W;
	localparam int P1 = P0 + deq_pkg::IDX_W;
	localparam int P2 = P1 + deq_pkg::VAL_W;

	deq_pkg::res_t                res;
	logic                         res_valid;
	logic                         res_ready;
	logic                         m_tvalid_q;
	logic [deq_pkg::OUT_W-1:0]    m_tdata_q;

	deq_core #(
		.CAPACITY (CAPACITY)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tdata[P0-1:0]),
		.in_index  (s_tdata[P1-1:P0]),
		.in_value  (s_tdata[P2-1:P1]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {{(deq_pkg::OUT_W - deq_pkg::RES_BITS){1'b0}}, res.reversed,
				res.count, res.right_end, res.left_end, res.ok, res.read_value};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[64] |-> m_tdata[63:0] == '0)
		else $error("failed request carries a non-zero read value");

	a_empty_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(CAPACITY < 2048) && m_tvalid && m_tdata[203:193] == '0
		|-> m_tdata[128:65] == '0 && m_tdata[192:129] == '0)
		else $error("empty deque reports non-zero ends");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while the previous one is in flight");

endmodule
